FILE: hw/rtl/polygon_hit_test_priority_defines.svh
// Assertion macros shared by the polygon hit test RTL.
`ifndef POLYGON_HIT_TEST_PRIORITY_DEFINES_SVH
`define POLYGON_HIT_TEST_PRIORITY_DEFINES_SVH

// Check a condition on every clock edge outside reset.
`define PHTP_CHECK(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define PHTP_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/phtp_pkg.sv
// Types and constants of the polygon hit test block.
`timescale 1ns / 1ps
`default_nettype none

package phtp_pkg;

  localparam int COORD_BITS = 32;
  localparam int ROAD_BITS  = 16;
  localparam int PRIO_BITS  = 16;
  localparam int DIFF_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS  = 2 * DIFF_BITS;

  localparam logic [1:0] OP_QUERY  = 2'd0;
  localparam logic [1:0] OP_VERTEX = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;

  localparam logic [1:0] MIN_RING_SEEN = 2'd2;
  localparam logic [1:0] SEEN_MAX      = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [PRIO_BITS-1:0]  prio_t;
  typedef logic [ROAD_BITS-1:0]         road_t;

  typedef enum logic [1:0] {
    K_QUERY,
    K_VERTEX,
    K_FINISH
  } kind_t;

  typedef struct packed {
    logic [1:0] operation;
    coord_t     coord_x;
    coord_t     coord_y;
    road_t      road_id;
    prio_t      priority_req;
    logic       ring_end;
  } cmd_t;

  typedef struct packed {
    logic  found;
    road_t hit_road;
  } rsp_t;

  typedef struct packed {
    kind_t  kind;
    coord_t x;
    coord_t y;
    road_t  road;
    prio_t  prio;
    logic   ring_end;
  } qitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  typedef struct packed {
    diff_t dqx;
    diff_t d;
    diff_t dbx;
    diff_t dqy;
    logic  live;
    logic  dpos;
  } edge_prep_t;

  typedef struct packed {
    prod_t lhs;
    prod_t rhs;
    logic  live;
    logic  dpos;
  } edge_prod_t;

endpackage

`default_nettype wire

FILE: hw/rtl/phtp_front.sv
// Front end: accepts command transfers, classifies them and queues those with a known operation.
`timescale 1ns / 1ps
`default_nettype none

module phtp_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cmd_valid,
  output logic                 cmd_stall,
  input  wire phtp_pkg::cmd_t  cmd,
  input  wire phtp_pkg::qstat_t q_stat,
  output logic                 q_push,
  output phtp_pkg::qitem_t     q_item
);
  import phtp_pkg::*;

  logic   hold;
  logic   keep;
  kind_t  kind;
  logic   take;
  qitem_t item;

  always_comb begin
    keep = 1'b1;
    case (cmd.operation)
      OP_QUERY:  kind = K_QUERY;
      OP_VERTEX: kind = K_VERTEX;
      OP_FINISH: kind = K_FINISH;
      default: begin
        kind = K_QUERY;
        keep = 1'b0;
      end
    endcase
  end

  assign cmd_stall = hold && q_stat.full;
  assign take      = cmd_valid && !cmd_stall;
  assign q_push    = hold && !q_stat.full;
  assign q_item    = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (take) begin
      hold <= keep;
    end else if (q_push) begin
      hold <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item.kind     <= kind;
      item.x        <= cmd.coord_x;
      item.y        <= cmd.coord_y;
      item.road     <= cmd.road_id;
      item.prio     <= cmd.priority_req;
      item.ring_end <= cmd.ring_end;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/phtp_queue.sv
// Short queue of classified items between front and back end.
`timescale 1ns / 1ps
`default_nettype none
`include "polygon_hit_test_priority_defines.svh"

module phtp_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire phtp_pkg::qitem_t push_item,
  input  wire logic             pop,
  output phtp_pkg::qitem_t      head,
  output phtp_pkg::qstat_t      stat
);
  import phtp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qitem_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign stat.full  = (count == CNT_W'(DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = slots[rd_ptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `PHTP_CHECK(a_count_bound, count <= CNT_W'(DEPTH), "queue count beyond depth")
  `PHTP_CHECK_NEXT(a_push_lands, push && !stat.full && !pop, !stat.empty, "push lost")

endmodule

`default_nettype wire

FILE: hw/rtl/phtp_back.sv
// Back end: edge crossing pipeline, ring parity, priority pick and result register.
`timescale 1ns / 1ps
`default_nettype none
`include "polygon_hit_test_priority_defines.svh"

module phtp_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire phtp_pkg::qitem_t head,
  input  wire phtp_pkg::qstat_t q_stat,
  output logic                  pop,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output phtp_pkg::rsp_t        rsp
);
  import phtp_pkg::*;

  logic       adv;
  coord_t     query_x;
  coord_t     query_y;
  coord_t     first_x;
  coord_t     first_y;
  coord_t     prev_x;
  coord_t     prev_y;
  logic [1:0] vertex_seen;
  coord_t     ring_x;
  coord_t     ring_y;
  logic       is_first;

  logic       s1_valid;
  kind_t      s1_kind;
  logic       s1_ring_end;
  logic       s1_ring_ok;
  road_t      s1_road;
  prio_t      s1_prio;
  edge_prep_t s1_e0;
  edge_prep_t s1_e1;

  logic       s2_valid;
  kind_t      s2_kind;
  logic       s2_ring_end;
  logic       s2_ring_ok;
  road_t      s2_road;
  prio_t      s2_prio;
  edge_prod_t s2_e0;
  edge_prod_t s2_e1;

  logic       parity;
  logic       best_valid;
  road_t      best_road;
  prio_t      best_priority;
  logic       t0;
  logic       t1;
  logic       ring_parity;

  function automatic edge_prep_t edge_prep(input coord_t ax, input coord_t ay,
                                           input coord_t bx, input coord_t by,
                                           input coord_t qx, input coord_t qy,
                                           input logic en);
    edge_prep_t e;
    e.dqx  = DIFF_BITS'(qx) - DIFF_BITS'(ax);
    e.d    = DIFF_BITS'(by) - DIFF_BITS'(ay);
    e.dbx  = DIFF_BITS'(bx) - DIFF_BITS'(ax);
    e.dqy  = DIFF_BITS'(qy) - DIFF_BITS'(ay);
    e.live = en && ((ay > qy) != (by > qy));
    e.dpos = by > ay;
    return e;
  endfunction

  function automatic edge_prod_t edge_mult(input edge_prep_t e);
    edge_prod_t p;
    p.lhs  = PROD_BITS'(e.dqx) * PROD_BITS'(e.d);
    p.rhs  = PROD_BITS'(e.dbx) * PROD_BITS'(e.dqy);
    p.live = e.live;
    p.dpos = e.dpos;
    return p;
  endfunction

  function automatic logic edge_toggle(input edge_prod_t p);
    return p.live && (p.dpos ? (p.lhs < p.rhs) : (p.lhs > p.rhs));
  endfunction

  assign adv      = !rsp_valid || !rsp_stall;
  assign pop      = adv && !q_stat.empty;
  assign is_first = (vertex_seen == '0);
  assign ring_x   = is_first ? head.x : first_x;
  assign ring_y   = is_first ? head.y : first_y;

  // Edge setup: differences against the query point.
  always_ff @(posedge clk) begin
    if (rst) begin
      query_x     <= '0;
      query_y     <= '0;
      vertex_seen <= '0;
      s1_valid    <= 1'b0;
    end else if (adv) begin
      s1_valid <= pop;
      if (pop) begin
        case (head.kind)
          K_QUERY: begin
            query_x     <= head.x;
            query_y     <= head.y;
            vertex_seen <= '0;
          end
          K_VERTEX: begin
            if (head.ring_end) begin
              vertex_seen <= '0;
            end else if (vertex_seen != SEEN_MAX) begin
              vertex_seen <= vertex_seen + 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && pop) begin
      s1_kind     <= head.kind;
      s1_ring_end <= head.ring_end;
      s1_ring_ok  <= vertex_seen >= MIN_RING_SEEN;
      s1_road     <= head.road;
      s1_prio     <= head.prio;
      s1_e0       <= edge_prep(head.x, head.y, prev_x, prev_y, query_x, query_y,
                               !is_first);
      s1_e1       <= edge_prep(ring_x, ring_y, head.x, head.y, query_x, query_y,
                               head.ring_end);
      if (head.kind == K_VERTEX) begin
        prev_x <= head.x;
        prev_y <= head.y;
        if (is_first) begin
          first_x <= head.x;
          first_y <= head.y;
        end
      end
    end
  end

  // Cross products.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      s2_kind     <= s1_kind;
      s2_ring_end <= s1_ring_end;
      s2_ring_ok  <= s1_ring_ok;
      s2_road     <= s1_road;
      s2_prio     <= s1_prio;
      s2_e0       <= edge_mult(s1_e0);
      s2_e1       <= edge_mult(s1_e1);
    end
  end

  // Compare, fold parity, pick the winning ring.
  assign t0          = edge_toggle(s2_e0);
  assign t1          = edge_toggle(s2_e1);
  assign ring_parity = parity ^ t0 ^ t1;

  always_ff @(posedge clk) begin
    if (rst) begin
      parity        <= 1'b0;
      best_valid    <= 1'b0;
      best_road     <= '0;
      best_priority <= '0;
      rsp_valid     <= 1'b0;
    end else if (adv) begin
      rsp_valid <= s2_valid && (s2_kind == K_FINISH);
      if (s2_valid) begin
        case (s2_kind)
          K_QUERY: begin
            parity        <= 1'b0;
            best_valid    <= 1'b0;
            best_road     <= '0;
            best_priority <= '0;
          end
          K_VERTEX: begin
            if (s2_ring_end) begin
              parity <= 1'b0;
              if (s2_ring_ok && ring_parity &&
                  (!best_valid || (s2_prio >= best_priority))) begin
                best_valid    <= 1'b1;
                best_road     <= s2_road;
                best_priority <= s2_prio;
              end
            end else begin
              parity <= ring_parity;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid && (s2_kind == K_FINISH)) begin
      rsp.found    <= best_valid;
      rsp.hit_road <= best_road;
    end
  end

  `PHTP_CHECK(a_miss_zero_road, !(rsp_valid && !rsp.found) || (rsp.hit_road == '0),
              "miss reported with nonzero road")
  `PHTP_CHECK(a_best_clear, best_valid || ((best_road == '0) && (best_priority == '0)),
              "best ring fields set without a hit")
  `PHTP_CHECK_NEXT(a_freeze, s2_valid && !adv, s2_valid, "pipeline item dropped during stall")
  `PHTP_CHECK(a_pop_free, !pop || adv, "pop while result register blocked")

endmodule

`default_nettype wire

FILE: hw/rtl/polygon_hit_test_priority.sv
// Top level of the polygon hit test with priority pick.
`timescale 1ns / 1ps
`default_nettype none

// Streams polygon rings against one query point and reports the containing
// ring with the highest sort index (later ring on ties). The block takes one
// command transfer per clock unless the queue is full: every vertex tests its
// incoming edge and, on the ring's last vertex, the closing edge in parallel,
// through a three-stage back end (edge setup, two pairs of cross multipliers,
// compare and pick). A finish command's result passes the front register, the
// queue slot, edge setup, cross products and the result register; the front
// register and a QUEUE_DEPTH-entry queue keep commands flowing while a result
// waits in the output register. Only a held result stalls the back end.
module polygon_hit_test_priority #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cmd_valid,
  output logic                cmd_stall,
  input  wire phtp_pkg::cmd_t cmd,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output phtp_pkg::rsp_t      rsp
);
  import phtp_pkg::*;

  logic   q_push;
  logic   q_pop;
  qitem_t q_item;
  qitem_t q_head;
  qstat_t q_stat;

  phtp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  phtp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  phtp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_stat    (q_stat),
    .pop       (q_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

FILE: test/hit_test_checker.sv
// Checker that predicts and compares the results of the polygon hit test.
`timescale 1ns / 1ps

module hit_test_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  logic             cmd_stall,
  input  phtp_pkg::cmd_t   cmd,
  input  logic             rsp_valid,
  input  logic             rsp_stall,
  input  phtp_pkg::rsp_t   rsp,
  output int               failures,
  output int               waiting
);
  import phtp_pkg::*;

  localparam int MIN_RING_VERTS = 3;

  coord_t pt_x, pt_y, ring_x0, ring_y0, tail_x, tail_y;
  int     seen;
  logic   odd;
  logic   have_best;
  road_t  best_road;
  prio_t  best_prio;
  rsp_t   hit_q[$];
  int     bad = 0;

  // Crossing test of the edge from a to b against the held point.
  function automatic logic crosses(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    diff_t dy, dqx, dbx, dqy;
    prod_t lhs, rhs;
    if ((ay > pt_y) == (by > pt_y)) return 1'b0;
    dy  = diff_t'(by) - diff_t'(ay);
    dqx = diff_t'(pt_x) - diff_t'(ax);
    dbx = diff_t'(bx) - diff_t'(ax);
    dqy = diff_t'(pt_y) - diff_t'(ay);
    lhs = prod_t'(dqx) * prod_t'(dy);
    rhs = prod_t'(dbx) * prod_t'(dqy);
    return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  task automatic clear_search();
    seen      = 0;
    odd       = 1'b0;
    have_best = 1'b0;
    best_road = '0;
    best_prio = '0;
  endtask

  task automatic absorb(cmd_t c);
    coord_t vx, vy;
    prio_t  p;
    rsp_t   r;
    vx = c.coord_x;
    vy = c.coord_y;
    p  = c.priority_req;
    case (c.operation)
      OP_QUERY: begin
        pt_x = vx;
        pt_y = vy;
        clear_search();
      end
      OP_VERTEX: begin
        if (seen == 0) begin
          ring_x0 = vx;
          ring_y0 = vy;
          odd     = 1'b0;
          seen    = 1;
        end else begin
          if (crosses(vx, vy, tail_x, tail_y)) odd = ~odd;
          if (seen < MIN_RING_VERTS) seen++;
        end
        tail_x = vx;
        tail_y = vy;
        if (c.ring_end) begin
          if (crosses(ring_x0, ring_y0, vx, vy)) odd = ~odd;
          if (seen >= MIN_RING_VERTS && odd && (!have_best || p >= best_prio)) begin
            have_best = 1'b1;
            best_road = c.road_id;
            best_prio = p;
          end
          seen = 0;
          odd  = 1'b0;
        end
      end
      OP_FINISH: begin
        r.found    = have_best;
        r.hit_road = have_best ? best_road : '0;
        hit_q.push_back(r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    rsp_t want;
    if (rst) begin
      pt_x    = '0;
      pt_y    = '0;
      ring_x0 = '0;
      ring_y0 = '0;
      tail_x  = '0;
      tail_y  = '0;
      clear_search();
      hit_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (hit_q.size() == 0) begin
          bad++;
          $display("%0t: unexpected result found=%0d hit_road=%0d",
                   $time, rsp.found, rsp.hit_road);
        end else begin
          want = hit_q.pop_front();
          if (rsp.found !== want.found) begin
            bad++;
            $display("%0t: found expected %0d actual %0d", $time, want.found, rsp.found);
          end
          if (rsp.hit_road !== want.hit_road) begin
            bad++;
            $display("%0t: hit_road expected %0d actual %0d",
                     $time, want.hit_road, rsp.hit_road);
          end
        end
      end
      if (cmd_valid && !cmd_stall) absorb(cmd);
    end
    failures <= bad;
    waiting  <= hit_q.size();
  end

endmodule

FILE: test/testbench.sv
// Top of the polygon hit test testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
  import phtp_pkg::*;

  localparam logic [1:0] OP_IGNORED = 2'd3;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_LIMIT   = 5000;
  localparam int ITEM_GOAL    = 1600;
  localparam coord_t C_MIN    = coord_t'(32'h8000_0000);
  localparam coord_t C_MAX    = coord_t'(32'h7fff_ffff);

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  int   failures;
  int   waiting;
  int   sent      = 0;
  int   idle      = 0;
  logic calm      = 1'b0;
  logic hold_now  = 1'b0;

  always #5 clk = ~clk;

  polygon_hit_test_priority dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  hit_test_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .failures  (failures),
    .waiting   (waiting)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic cmd_t item(logic [1:0] op, coord_t x, coord_t y, road_t road,
                                prio_t prio, logic fin);
    cmd_t c;
    c.operation    = op;
    c.coord_x      = x;
    c.coord_y      = y;
    c.road_id      = road;
    c.priority_req = prio;
    c.ring_end     = fin;
    return c;
  endfunction

  function automatic cmd_t noise();
    logic [127:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom};
    return raw[$bits(cmd_t)-1:0];
  endfunction

  function automatic coord_t near(coord_t c, int span);
    longint v;
    v = longint'(c) + longint'($urandom_range(0, 2 * span)) - longint'(span);
    return coord_t'(v);
  endfunction

  task automatic send(cmd_t c);
    int gap;
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall !== 1'b0) @(posedge clk);
    if (c.operation != OP_IGNORED) sent++;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off new transfers until every pending result is back.
  task automatic settle();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Usually one query, a few rings around it, then a finish.
  task automatic scene();
    coord_t qx, qy, vx, vy, py;
    int     mode, span, rings, nv, r, v, k;
    road_t  rd;
    prio_t  pr;
    logic   closed;
    calm = ($urandom_range(0, 5) == 0);
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      qx   = $urandom;
      qy   = $urandom;
      span = 0;
    end else begin
      qx   = near('0, 1 << 29);
      qy   = near('0, 1 << 29);
      span = (mode < 5) ? 16 : (mode < 8) ? 4096 : (1 << 20);
    end
    if ($urandom_range(0, 9) != 0)
      send(item(OP_QUERY, qx, qy, road_t'($urandom), prio_t'($urandom), 1'($urandom)));
    rings = $urandom_range(1, 5);
    for (r = 0; r < rings; r++) begin
      nv     = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      rd     = road_t'($urandom);
      pr     = ($urandom_range(0, 1) != 0) ? prio_t'(int'($urandom_range(0, 4)) - 2)
                                           : prio_t'($urandom);
      closed = ($urandom_range(0, 19) != 0);
      py     = qy;
      for (v = 0; v < nv; v++) begin
        if (span == 0) begin
          vx = $urandom;
          vy = $urandom;
        end else begin
          vx = near(qx, span);
          vy = near(qy, span);
        end
        k = $urandom_range(0, 15);
        if (k == 0) vy = qy;
        else if (k == 1) vy = py;
        else if (k == 2) vx = qx;
        if ($urandom_range(0, 24) == 0) send(noise());
        if (v == nv - 1) send(item(OP_VERTEX, vx, vy, rd, pr, closed));
        else send(item(OP_VERTEX, vx, vy, road_t'($urandom), prio_t'($urandom), 1'b0));
        py = vy;
      end
    end
    send(item(OP_FINISH, $urandom, $urandom, road_t'($urandom), prio_t'($urandom),
              1'($urandom)));
    if ($urandom_range(0, 7) == 0)
      send(item(OP_FINISH, $urandom, $urandom, road_t'($urandom), prio_t'($urandom),
                1'($urandom)));
  endtask

  initial begin : receiver
    int n;
    forever begin
      if (hold_now) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_now = 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(30, 80)) @(posedge clk);
      end else begin
        n = idle_len();
        rsp_stall <= 1'b0;
        @(posedge clk);
        if (n > 0) begin
          rsp_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) idle <= 0;
    else idle <= idle + 1;
    if (idle >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    logic held, paused;
    held   = 1'b0;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // vertices before any query test against the origin
    send(item(OP_VERTEX, -1024, -1024, 16'd1, 16'sd0, 1'b0));
    send(item(OP_VERTEX, 1024, -1024, 16'd2, 16'sd0, 1'b0));
    send(item(OP_VERTEX, 0, 1024, 16'd5, 16'sd0, 1'b1));
    send(item(OP_FINISH, '0, '0, '0, '0, 1'b0));
    send(item(OP_QUERY, '0, '0, '0, '0, 1'b0));
    send(item(OP_VERTEX, C_MIN, C_MIN, '0, '0, 1'b0));
    send(item(OP_VERTEX, C_MAX, C_MIN, '0, '0, 1'b0));
    send(item(OP_VERTEX, 0, C_MAX, 16'hffff, -16'sd32768, 1'b1));
    // square with horizontal edges, same priority: later ring wins
    send(item(OP_VERTEX, -10, -10, '0, '0, 1'b0));
    send(item(OP_VERTEX, 10, -10, '0, '0, 1'b0));
    send(item(OP_VERTEX, 10, 10, '0, '0, 1'b0));
    send(item(OP_VERTEX, -10, 10, 16'd7, -16'sd32768, 1'b1));
    // short rings drop out
    send(item(OP_VERTEX, -5, -5, '0, '0, 1'b0));
    send(item(OP_VERTEX, 5, 5, 16'd9, 16'sd32767, 1'b1));
    send(item(OP_VERTEX, 0, 0, 16'd11, 16'sd32767, 1'b1));
    send(item(OP_IGNORED, C_MAX, C_MIN, 16'hffff, 16'sd32767, 1'b1));
    send(item(OP_FINISH, C_MIN, C_MAX, 16'hffff, -16'sd1, 1'b1));
    send(item(OP_FINISH, '0, '0, '0, '0, 1'b0));
    send(item(OP_QUERY, 1, 1, 16'hffff, -16'sd1, 1'b1));
    send(item(OP_VERTEX, -4, -4, '0, '0, 1'b0));
    send(item(OP_VERTEX, 4, -4, '0, '0, 1'b0));
    send(item(OP_VERTEX, 0, 4, 16'd0, 16'sd32767, 1'b1));
    send(item(OP_FINISH, '0, '0, '0, '0, 1'b0));
    send(item(OP_QUERY, C_MAX, C_MIN, '0, '0, 1'b0));
    send(item(OP_FINISH, '0, '0, '0, '0, 1'b0));
    settle();

    while (sent < ITEM_GOAL) begin
      if (!held && sent >= 400) begin
        hold_now = 1'b1;
        held     = 1'b1;
      end
      if (!paused && sent >= 900) begin
        settle();
        paused = 1'b1;
      end
      scene();
    end
    settle();

    if (failures == 0 && waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
